// File: src/ttch_pkg.sv
package ttch_pkg;

  localparam int ROWS   = 32;
  localparam int COLS   = 64;
  localparam int DEPTH  = ROWS * COLS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    OP_READ,
    OP_CR,
    OP_LF,
    OP_BS,
    OP_FF,
    OP_PUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             in_range;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       ch;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [4:0] cur_row;
    logic [5:0] cur_col;
    logic       scrolled;
    logic       cleared;
  } res_t;

endpackage

// File: src/ttch_front.sv
module ttch_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              kind,
  input  logic [7:0]        char_code,
  input  logic [4:0]        read_row,
  input  logic [5:0]        read_col,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output ttch_pkg::cmd_t    cmd
);

  ttch_pkg::cmd_t q [2];
  ttch_pkg::cmd_t dec;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_take;

  always_comb begin
    dec.ch       = char_code;
    dec.row      = ttch_pkg::ROW_W'(read_row);
    dec.col      = ttch_pkg::COL_W'(read_col);
    dec.in_range = (int'(read_row) < ttch_pkg::ROWS) && (int'(read_col) < ttch_pkg::COLS);
    if (kind) begin
      dec.op = ttch_pkg::OP_READ;
    end else begin
      case (char_code)
        ttch_pkg::CH_CR: dec.op = ttch_pkg::OP_CR;
        ttch_pkg::CH_LF: dec.op = ttch_pkg::OP_LF;
        ttch_pkg::CH_BS: dec.op = ttch_pkg::OP_BS;
        ttch_pkg::CH_FF: dec.op = ttch_pkg::OP_FF;
        default:         dec.op = ttch_pkg::OP_PUT;
      endcase
    end
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_take   = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/ttch_back.sv
module ttch_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  ttch_pkg::cmd_t    cmd,
  input  logic              res_room,
  output logic              res_push,
  output ttch_pkg::res_t    res
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_FILL   = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t                       state;
  ttch_pkg::cmd_t               cmd_r;
  logic [ttch_pkg::ROW_W-1:0]   pos_row;
  logic [ttch_pkg::COL_W-1:0]   pos_col;
  logic [ttch_pkg::ROW_W-1:0]   top;
  logic [ttch_pkg::ROWS-1:0]    row_valid;
  logic [ttch_pkg::COL_W-1:0]   fill_col;
  logic [7:0]                   res_cell;
  logic                         res_scrolled;
  logic                         res_cleared;

  logic [7:0]                   mem [ttch_pkg::DEPTH];
  logic [7:0]                   rd_data;
  logic                         wr_en;
  logic                         rd_en;
  logic [7:0]                   wr_data;
  logic [ttch_pkg::ADDR_W-1:0]  addr;

  logic [ttch_pkg::ROW_W-1:0]   sel_row;
  logic [ttch_pkg::ROW_W:0]     row_sum;
  logic [ttch_pkg::ROW_W-1:0]   phys;
  logic [ttch_pkg::COL_W-1:0]   sel_col;
  logic [ttch_pkg::ROW_W-1:0]   top_inc;
  logic                         phys_valid;
  logic                         at_last_col;
  logic                         at_last_row;
  logic                         is_put;
  logic                         is_read;

  assign is_put  = (cmd_r.op == ttch_pkg::OP_PUT);
  assign is_read = (cmd_r.op == ttch_pkg::OP_READ);

  // logical row -> physical row through the scroll offset
  always_comb begin
    sel_row = is_read ? cmd_r.row : pos_row;
    row_sum = {1'b0, top} + {1'b0, sel_row};
    if (row_sum >= (ttch_pkg::ROW_W + 1)'(ttch_pkg::ROWS)) begin
      phys = ttch_pkg::ROW_W'(row_sum - (ttch_pkg::ROW_W + 1)'(ttch_pkg::ROWS));
    end else begin
      phys = ttch_pkg::ROW_W'(row_sum);
    end
    if (is_read) begin
      sel_col = cmd_r.col;
    end else if (state == ST_FILL) begin
      sel_col = fill_col;
    end else begin
      sel_col = pos_col;
    end
    addr = ttch_pkg::ADDR_W'(phys) * ttch_pkg::ADDR_W'(ttch_pkg::COLS)
         + ttch_pkg::ADDR_W'(sel_col);
  end

  assign phys_valid  = row_valid[phys];
  assign top_inc     = (top == ttch_pkg::ROW_W'(ttch_pkg::ROWS - 1)) ? '0 : top + 1'b1;
  assign at_last_col = (pos_col == ttch_pkg::COL_W'(ttch_pkg::COLS - 1));
  assign at_last_row = (pos_row == ttch_pkg::ROW_W'(ttch_pkg::ROWS - 1));

  assign wr_en   = (state == ST_FILL) || (state == ST_EXEC && is_put && phys_valid);
  assign wr_data = (state == ST_FILL) ? ttch_pkg::CH_SPACE : cmd_r.ch;
  assign rd_en   = (state == ST_EXEC) && is_read && cmd_r.in_range && phys_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign cmd_take = (state == ST_IDLE) && cmd_valid && res_room;
  assign res_push = (state == ST_RESULT);

  always_comb begin
    res.cell_char = res_cell;
    res.cur_row   = 5'(pos_row);
    res.cur_col   = 6'(pos_col);
    res.scrolled  = res_scrolled;
    res.cleared   = res_cleared;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos_row    <= '0;
      pos_col    <= '0;
      top        <= '0;
      row_valid  <= '0;
      fill_col   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            cmd_r        <= cmd;
            res_cell     <= 8'h00;
            res_scrolled <= 1'b0;
            res_cleared  <= 1'b0;
            state        <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_RESULT;
          case (cmd_r.op)
            ttch_pkg::OP_READ: begin
              if (cmd_r.in_range) begin
                if (phys_valid) begin
                  state <= ST_RDWAIT;
                end else begin
                  res_cell <= ttch_pkg::CH_SPACE;
                end
              end
            end
            ttch_pkg::OP_CR: begin
              pos_col <= '0;
            end
            ttch_pkg::OP_BS: begin
              if (pos_col != '0) begin
                pos_col <= pos_col - 1'b1;
              end
            end
            ttch_pkg::OP_FF: begin
              row_valid   <= '0;
              top         <= '0;
              pos_row     <= '0;
              pos_col     <= '0;
              res_cleared <= 1'b1;
            end
            ttch_pkg::OP_LF, ttch_pkg::OP_PUT: begin
              if (is_put && !phys_valid) begin
                // row stale since scroll/clear: blank it first
                fill_col <= '0;
                state    <= ST_FILL;
              end else if (is_put && !at_last_col) begin
                pos_col <= pos_col + 1'b1;
              end else begin
                pos_col <= '0;
                if (at_last_row) begin
                  row_valid[top] <= 1'b0;
                  top            <= top_inc;
                  res_scrolled   <= 1'b1;
                end else begin
                  pos_row <= pos_row + 1'b1;
                end
              end
            end
            default: begin
              state <= ST_RESULT;
            end
          endcase
        end
        ST_FILL: begin
          fill_col <= fill_col + 1'b1;
          if (fill_col == ttch_pkg::COL_W'(ttch_pkg::COLS - 1)) begin
            row_valid[phys] <= 1'b1;
            state           <= ST_EXEC;
          end
        end
        ST_RDWAIT: begin
          res_cell <= rd_data;
          state    <= ST_RESULT;
        end
        ST_RESULT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/ttch_outq.sv
module ttch_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  ttch_pkg::res_t    res,
  output logic              res_room,
  output logic              empty,
  input  logic              pop,
  output ttch_pkg::res_t    head
);

  ttch_pkg::res_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_pop;

  assign res_room = (count != 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = q[rd_ptr];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({res_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/text_terminal_char_handler_unit.sv
// Path: front queue, then back-end states IDLE, EXEC and RESULT, then result queue;
// a cell read of a live row adds RDWAIT, and a printable byte landing on a row not yet
// written since a scroll or clear adds FILL, where the row is blanked one cell per
// cycle (single RAM port). Back end is serial: a new word waits for the last result.
// Reset: cursor to 0,0, scroll offset 0, all row-valid bits cleared so the screen
// reads as spaces at once; both queues empty. No RAM clearing pass.
module text_terminal_char_handler_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       kind,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [5:0] read_col,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] cell_char,
  output logic [4:0] cur_row,
  output logic [5:0] cur_col,
  output logic       scrolled,
  output logic       cleared
);

  ttch_pkg::cmd_t cmd;
  ttch_pkg::res_t res;
  ttch_pkg::res_t head;
  logic           cmd_valid;
  logic           cmd_take;
  logic           res_room;
  logic           res_push;

  ttch_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  ttch_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .res_room  (res_room),
    .res_push  (res_push),
    .res       (res)
  );

  ttch_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_room (res_room),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign cell_char = head.cell_char;
  assign cur_row   = head.cur_row;
  assign cur_col   = head.cur_col;
  assign scrolled  = head.scrolled;
  assign cleared   = head.cleared;

endmodule

// File: src/ttch_chk.sv
module ttch_chk (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] cell_char,
  input logic [4:0] cur_row,
  input logic [5:0] cur_col,
  input logic       scrolled,
  input logic       cleared
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (!empty && cleared) |-> (cur_row == 5'd0 && cur_col == 6'd0 && !scrolled))
    else $error("clear word without home cursor");

  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    (!empty && scrolled) |-> (cur_col == 6'd0 && cell_char == 8'h00))
    else $error("scroll word with cursor off column 0");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(cell_char) && $stable(cur_row)
                          && $stable(cur_col) && $stable(scrolled) && $stable(cleared)))
    else $error("stalled result word changed");

endmodule

bind text_terminal_char_handler_unit ttch_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .cell_char (cell_char),
  .cur_row   (cur_row),
  .cur_col   (cur_col),
  .scrolled  (scrolled),
  .cleared   (cleared)
);

// File: dv/text_terminal_char_handler_unit_tb.sv
`timescale 1ns / 1ps

module text_terminal_char_handler_unit_tb;

  class screen_scoreboard;
    logic [7:0]                 cells[ttch_pkg::DEPTH];
    logic [ttch_pkg::ROW_W-1:0] crow;
    logic [ttch_pkg::COL_W-1:0] ccol;
    ttch_pkg::res_t             expected_q[$];
    int                         fails;
    int                         n_words, n_reads, n_scrolls, n_clears, n_wraps;

    function new();
      foreach (cells[i]) cells[i] = ttch_pkg::CH_SPACE;
      crow = '0;
      ccol = '0;
      fails = 0;
      n_words = 0;
      n_reads = 0;
      n_scrolls = 0;
      n_clears = 0;
      n_wraps = 0;
    endfunction

    function ttch_pkg::op_t decode(bit k, logic [7:0] c);
      if (k) return ttch_pkg::OP_READ;
      case (c)
        ttch_pkg::CH_CR: return ttch_pkg::OP_CR;
        ttch_pkg::CH_LF: return ttch_pkg::OP_LF;
        ttch_pkg::CH_BS: return ttch_pkg::OP_BS;
        ttch_pkg::CH_FF: return ttch_pkg::OP_FF;
        default:         return ttch_pkg::OP_PUT;
      endcase
    endfunction

    function bit advance_line();
      ccol = '0;
      if (crow < ttch_pkg::ROWS - 1) begin
        crow = crow + 1'b1;
        return 1'b0;
      end
      for (int i = 0; i < (ttch_pkg::ROWS - 1) * ttch_pkg::COLS; i++)
        cells[i] = cells[i + ttch_pkg::COLS];
      for (int i = (ttch_pkg::ROWS - 1) * ttch_pkg::COLS; i < ttch_pkg::DEPTH; i++)
        cells[i] = ttch_pkg::CH_SPACE;
      return 1'b1;
    endfunction

    function void note_word(bit k, logic [7:0] c, logic [4:0] rr, logic [5:0] rc);
      ttch_pkg::res_t e;
      e = '0;
      n_words++;
      case (decode(k, c))
        ttch_pkg::OP_READ: begin
          n_reads++;
          if (rr < ttch_pkg::ROWS && rc < ttch_pkg::COLS)
            e.cell_char = cells[rr * ttch_pkg::COLS + rc];
        end
        ttch_pkg::OP_CR: ccol = '0;
        ttch_pkg::OP_LF: e.scrolled = advance_line();
        ttch_pkg::OP_BS: if (ccol != 0) ccol = ccol - 1'b1;
        ttch_pkg::OP_FF: begin
          foreach (cells[i]) cells[i] = ttch_pkg::CH_SPACE;
          crow = '0;
          ccol = '0;
          e.cleared = 1'b1;
          n_clears++;
        end
        default: begin
          cells[crow * ttch_pkg::COLS + ccol] = c;
          if (ccol < ttch_pkg::COLS - 1) begin
            ccol = ccol + 1'b1;
          end else begin
            n_wraps++;
            e.scrolled = advance_line();
          end
        end
      endcase
      if (e.scrolled) n_scrolls++;
      e.cur_row = 5'(crow);
      e.cur_col = 6'(ccol);
      expected_q.push_back(e);
    endfunction

    function void check_word(ttch_pkg::res_t got);
      ttch_pkg::res_t e;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("ERROR: unexpected result word %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.cell_char !== e.cell_char || got.cur_row !== e.cur_row ||
          got.cur_col !== e.cur_col || got.scrolled !== e.scrolled ||
          got.cleared !== e.cleared) begin
        fails++;
        if (fails <= 10) begin
          $display("ERROR: exp cell=%h row=%0d col=%0d scr=%b clr=%b",
                   e.cell_char, e.cur_row, e.cur_col, e.scrolled, e.cleared);
          $display("       got cell=%h row=%0d col=%0d scr=%b clr=%b",
                   got.cell_char, got.cur_row, got.cur_col, got.scrolled, got.cleared);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       kind = 1'b0;
  logic [7:0] char_code = '0;
  logic [4:0] read_row = '0;
  logic [5:0] read_col = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] cell_char;
  logic [4:0] cur_row;
  logic [5:0] cur_col;
  logic       scrolled;
  logic       cleared;

  screen_scoreboard sb = new();
  int burst_left = 1;

  text_terminal_char_handler_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .empty     (empty),
    .pop       (pop),
    .cell_char (cell_char),
    .cur_row   (cur_row),
    .cur_col   (cur_col),
    .scrolled  (scrolled),
    .cleared   (cleared)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("ERROR: timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: stall pattern is re-chosen at random as the run goes on
  int         pop_tick = 0;
  int         pop_mode = 0;
  logic [7:0] pop_pat = 8'hFF;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        sb.check_word('{cell_char: cell_char, cur_row: cur_row, cur_col: cur_col,
                        scrolled: scrolled, cleared: cleared});
      end
      pop_tick++;
      if (pop_tick % 50 == 0) begin
        pop_mode = $urandom_range(0, 3);
        pop_pat  = 8'($urandom);
      end
      case (pop_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= pop_pat[pop_tick % 8];
        default: pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic send_word(bit k, logic [7:0] c, logic [4:0] rr, logic [5:0] rc);
    int gap;
    kind      <= k;
    char_code <= c;
    read_row  <= rr;
    read_col  <= rc;
    push      <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_word(k, c, rr, rc);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put_char(logic [7:0] c);
    send_word(1'b0, c, 5'($urandom), 6'($urandom));
  endtask

  task automatic read_cell(logic [4:0] rr, logic [5:0] rc);
    send_word(1'b1, 8'($urandom), rr, rc);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ttch_pkg::CH_CR || c == ttch_pkg::CH_LF ||
           c == ttch_pkg::CH_BS || c == ttch_pkg::CH_FF);
    return c;
  endfunction

  initial begin
    int n;
    int pick;
    int len;
    int next_drain;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed
    read_cell(5'd0, 6'd0);
    read_cell(5'd31, 6'd63);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(5'd0, 6'd0);
    read_cell(5'd0, 6'd1);
    read_cell(5'd0, 6'd2);
    put_char(ttch_pkg::CH_BS);
    put_char(ttch_pkg::CH_CR);
    put_char(ttch_pkg::CH_BS);
    put_char(ttch_pkg::CH_LF);
    put_char(8'h5A);
    read_cell(5'd1, 6'd0);
    put_char(ttch_pkg::CH_FF);
    read_cell(5'd1, 6'd0);
    read_cell(5'd0, 6'd0);
    drain();

    // random
    n = 0;
    next_drain = 400;
    while (n < 2000) begin
      if (n >= next_drain) begin
        drain();
        next_drain += 400;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        len = $urandom_range(50, 140);
        repeat (len) put_char(text_byte());
        n += len;
      end else begin
        if (pick < 15)
          read_cell(5'($urandom), 6'($urandom));
        else if (pick < 25)
          read_cell(sb.crow, (sb.ccol == 0) ? 6'd0 : sb.ccol - 1'b1);
        else if (pick < 35)
          put_char(ttch_pkg::CH_LF);
        else if (pick < 39)
          put_char(ttch_pkg::CH_CR);
        else if (pick < 44)
          put_char(ttch_pkg::CH_BS);
        else if (pick == 44 && $urandom_range(0, 3) == 0)
          put_char(ttch_pkg::CH_FF);
        else
          put_char(8'($urandom_range(0, 255)));
        n++;
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (ttch_pkg::COLS + 20) @(posedge clk);
    if (sb.pending() != 0) sb.fails++;

    $display("Covered %0d words: %0d cell reads, %0d line wraps, %0d scrolls, %0d screen clears",
             sb.n_words, sb.n_reads, sb.n_wraps, sb.n_scrolls, sb.n_clears);
    $display("Mismatches and stray words: %0d", sb.fails);
    if (sb.fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
src/ttch_pkg.sv
src/ttch_front.sv
src/ttch_back.sv
src/ttch_outq.sv
src/text_terminal_char_handler_unit.sv
src/ttch_chk.sv
dv/text_terminal_char_handler_unit_tb.sv
